>>> hdl/tlpt_pkg.sv
// ---------------------------------------------------------------------------
// tlpt_pkg
// Shared widths, codes and controller/datapath interface types for the
// two-level page table engine.
// ---------------------------------------------------------------------------
package tlpt_pkg;

   // fixed geometry
   localparam int DIR_ENTRIES   = 1024;
   localparam int TABLE_SLOTS   = 16;
   localparam int TABLE_ENTRIES = 1024;

   localparam int ADDR_W  = 32;
   localparam int FLAGS_W = 12;
   localparam int DIDX_W  = $clog2(DIR_ENTRIES);
   localparam int TIDX_W  = $clog2(TABLE_ENTRIES);
   localparam int SLOT_W  = $clog2(TABLE_SLOTS);
   localparam int NFREE_W = $clog2(TABLE_SLOTS + 1);
   localparam int TADDR_W = SLOT_W + TIDX_W;
   localparam int FRAME_W = ADDR_W - FLAGS_W;
   // one counter sweeps the directory and a table; both are 1024 deep
   localparam int SWEEP_W = DIDX_W;

   localparam logic [FLAGS_W-1:0] PRESENT_BIT = FLAGS_W'(1);

   // request kinds
   localparam logic [1:0] KIND_MAP   = 2'd0;
   localparam logic [1:0] KIND_UNMAP = 2'd1;
   localparam logic [1:0] KIND_XLATE = 2'd2;

   // result status codes
   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_NOMAP = 2'd1;
   localparam logic [1:0] ST_POOL  = 2'd2;

   typedef struct packed {
      logic              present;
      logic [SLOT_W-1:0] slot;
   } dir_entry_type;

   // controller to datapath
   typedef struct packed {
      logic       req_load;     // latch request word, read directory
      logic       dir_clr_wr;   // reset sweep write of directory
      logic       dir_alloc_wr; // hand out next free table
      logic       tbl_map_wr;   // write mapping into present table
      logic       tbl_zero_wr;  // unmap entry
      logic       tbl_clr_wr;   // sweep write of newly allocated table
      logic       tbl_rd;       // read entry for translate
      logic       cnt_clr;
      logic       cnt_inc;
      logic       rsp_load;
      logic       rsp_take_pte;
      logic [1:0] rsp_status;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [1:0] kind;
      logic       dir_present;
      logic       pool_full;
      logic       cnt_last;
      logic       pte_present;
   } sts_type;

endpackage

>>> hdl/tlpt_dp.sv
// ---------------------------------------------------------------------------
// tlpt_dp
// Datapath: request registers, directory and table memories, free-table
// counter, sweep counter and result registers.
// ---------------------------------------------------------------------------
module tlpt_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  tlpt_pkg::cmd_type             cmd,
   output tlpt_pkg::sts_type             sts,
   input  logic [1:0]                    req_kind,
   input  logic [tlpt_pkg::ADDR_W-1:0]   req_virt_addr,
   input  logic [tlpt_pkg::ADDR_W-1:0]   req_phys_addr,
   input  logic [tlpt_pkg::FLAGS_W-1:0]  req_page_flags,
   output logic [tlpt_pkg::ADDR_W-1:0]   rsp_phys_result,
   output logic                          rsp_mapped,
   output logic [1:0]                    rsp_status
);
   import tlpt_pkg::*;

   // memories
   dir_entry_type      dir_mem [DIR_ENTRIES];
   logic [ADDR_W-1:0]  tbl_mem [TABLE_SLOTS * TABLE_ENTRIES];

   // request word
   logic [1:0]         kind_ff;
   logic [ADDR_W-1:0]  va_ff;
   logic [ADDR_W-1:0]  map_val_ff;

   dir_entry_type      dir_q_ff;
   logic [ADDR_W-1:0]  pte_ff;
   logic [SLOT_W-1:0]  alloc_slot_ff;
   logic [NFREE_W-1:0] next_free_ff, next_free_in;
   logic [SWEEP_W-1:0] cnt_ff, cnt_in;

   logic [ADDR_W-1:0]  phys_ff, phys_in;
   logic               mapped_ff, mapped_in;
   logic [1:0]         status_ff, status_in;

   logic [DIDX_W-1:0]  didx;
   logic [TIDX_W-1:0]  tidx;
   logic [DIDX_W-1:0]  req_didx;
   logic               dir_wr;
   logic [DIDX_W-1:0]  dir_waddr;
   dir_entry_type      dir_wdata;
   logic               tbl_wr;
   logic [TADDR_W-1:0] tbl_waddr;
   logic [ADDR_W-1:0]  tbl_wdata;
   logic [TADDR_W-1:0] tbl_raddr;

   assign didx     = va_ff[ADDR_W-1 -: DIDX_W];
   assign tidx     = va_ff[FLAGS_W +: TIDX_W];
   assign req_didx = req_virt_addr[ADDR_W-1 -: DIDX_W];

   // directory write port
   always_comb begin
      dir_wr    = cmd.dir_clr_wr | cmd.dir_alloc_wr;
      dir_waddr = cmd.dir_clr_wr ? cnt_ff[DIDX_W-1:0] : didx;
      dir_wdata.present = cmd.dir_alloc_wr;
      dir_wdata.slot    = cmd.dir_alloc_wr ? next_free_ff[SLOT_W-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (dir_wr) begin
         dir_mem[dir_waddr] <= dir_wdata;
      end
      if (cmd.req_load) begin
         dir_q_ff <= dir_mem[req_didx];
      end
   end

   // table write port: map, unmap or clearing sweep
   always_comb begin
      tbl_wr    = cmd.tbl_map_wr | cmd.tbl_zero_wr | cmd.tbl_clr_wr;
      tbl_waddr = {dir_q_ff.slot, tidx};
      tbl_wdata = '0;
      priority if (cmd.tbl_clr_wr) begin
         tbl_waddr = {alloc_slot_ff, cnt_ff[TIDX_W-1:0]};
         // the requested entry gets its mapping as the sweep passes it
         tbl_wdata = (cnt_ff[TIDX_W-1:0] == tidx) ? map_val_ff : '0;
      end else if (cmd.tbl_map_wr) begin
         tbl_wdata = map_val_ff;
      end else begin
         tbl_wdata = '0;
      end
   end

   assign tbl_raddr = {dir_q_ff.slot, tidx};

   always_ff @(posedge clock) begin
      if (tbl_wr) begin
         tbl_mem[tbl_waddr] <= tbl_wdata;
      end
      if (cmd.tbl_rd) begin
         pte_ff <= tbl_mem[tbl_raddr];
      end
   end

   // request registers
   always_ff @(posedge clock) begin
      if (cmd.req_load) begin
         kind_ff    <= req_kind;
         va_ff      <= req_virt_addr;
         map_val_ff <= {req_phys_addr[ADDR_W-1:FLAGS_W], req_page_flags | PRESENT_BIT};
      end
      if (cmd.dir_alloc_wr) begin
         alloc_slot_ff <= next_free_ff[SLOT_W-1:0];
      end
   end

   // counters
   always_comb begin
      next_free_in = next_free_ff;
      if (cmd.dir_alloc_wr) begin
         next_free_in = next_free_ff + NFREE_W'(1);
      end
      cnt_in = cnt_ff;
      priority if (cmd.cnt_clr) begin
         cnt_in = '0;
      end else if (cmd.cnt_inc) begin
         cnt_in = cnt_ff + SWEEP_W'(1);
      end else begin
         cnt_in = cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_free_ff <= '0;
         cnt_ff       <= '0;
      end else begin
         next_free_ff <= next_free_in;
         cnt_ff       <= cnt_in;
      end
   end

   // result registers
   always_comb begin
      phys_in   = phys_ff;
      mapped_in = mapped_ff;
      status_in = status_ff;
      if (cmd.rsp_load) begin
         phys_in   = cmd.rsp_take_pte ? {pte_ff[ADDR_W-1:FLAGS_W], va_ff[FLAGS_W-1:0]} : '0;
         mapped_in = cmd.rsp_take_pte;
         status_in = cmd.rsp_status;
      end
   end

   always_ff @(posedge clock) begin
      phys_ff   <= phys_in;
      mapped_ff <= mapped_in;
      status_ff <= status_in;
   end

   assign rsp_phys_result = phys_ff;
   assign rsp_mapped      = mapped_ff;
   assign rsp_status      = status_ff;

   assign sts.kind        = kind_ff;
   assign sts.dir_present = dir_q_ff.present;
   assign sts.pool_full   = (next_free_ff == NFREE_W'(TABLE_SLOTS));
   assign sts.cnt_last    = (cnt_ff == {SWEEP_W{1'b1}});
   assign sts.pte_present = pte_ff[0];

endmodule

>>> hdl/tlpt_ctrl.sv
// ---------------------------------------------------------------------------
// tlpt_ctrl
// Controller: sequences directory clear, request decode, table access,
// table clearing on allocation and the result handshake.
// ---------------------------------------------------------------------------
module tlpt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  tlpt_pkg::sts_type sts,
   output tlpt_pkg::cmd_type cmd
);
   import tlpt_pkg::*;

   localparam logic [2:0] S_CLR_DIR = 3'd0;
   localparam logic [2:0] S_IDLE    = 3'd1;
   localparam logic [2:0] S_DIR     = 3'd2;
   localparam logic [2:0] S_TBL     = 3'd3;
   localparam logic [2:0] S_CLR_TBL = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_CLR_DIR: begin
            cmd.dir_clr_wr = 1'b1;
            cmd.cnt_inc    = 1'b1;
            if (sts.cnt_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.req_load = 1'b1;
               state_in     = S_DIR;
            end
         end
         S_DIR: begin
            unique case (sts.kind)
               KIND_MAP: begin
                  priority if (sts.dir_present) begin
                     if (out_free) begin
                        cmd.tbl_map_wr = 1'b1;
                        cmd.rsp_load   = 1'b1;
                        cmd.rsp_status = ST_DONE;
                        state_in       = S_IDLE;
                     end
                  end else if (sts.pool_full) begin
                     if (out_free) begin
                        cmd.rsp_load   = 1'b1;
                        cmd.rsp_status = ST_POOL;
                        state_in       = S_IDLE;
                     end
                  end else begin
                     cmd.dir_alloc_wr = 1'b1;
                     cmd.cnt_clr      = 1'b1;
                     state_in         = S_CLR_TBL;
                  end
               end
               KIND_UNMAP: begin
                  if (out_free) begin
                     cmd.tbl_zero_wr = sts.dir_present;
                     cmd.rsp_load    = 1'b1;
                     cmd.rsp_status  = sts.dir_present ? ST_DONE : ST_NOMAP;
                     state_in        = S_IDLE;
                  end
               end
               KIND_XLATE: begin
                  if (sts.dir_present) begin
                     cmd.tbl_rd = 1'b1;
                     state_in   = S_TBL;
                  end else if (out_free) begin
                     cmd.rsp_load   = 1'b1;
                     cmd.rsp_status = ST_NOMAP;
                     state_in       = S_IDLE;
                  end
               end
               default: begin
                  // unused kind: no change, plain done
                  if (out_free) begin
                     cmd.rsp_load   = 1'b1;
                     cmd.rsp_status = ST_DONE;
                     state_in       = S_IDLE;
                  end
               end
            endcase
         end
         S_TBL: begin
            if (out_free) begin
               cmd.rsp_load     = 1'b1;
               cmd.rsp_take_pte = sts.pte_present;
               cmd.rsp_status   = sts.pte_present ? ST_DONE : ST_NOMAP;
               state_in         = S_IDLE;
            end
         end
         S_CLR_TBL: begin
            // repeated writes of the last entry while stalled are harmless
            cmd.tbl_clr_wr = 1'b1;
            if (!sts.cnt_last) begin
               cmd.cnt_inc = 1'b1;
            end else if (out_free) begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_status = ST_DONE;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR_DIR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> hdl/two_level_page_table_engine.sv
// ---------------------------------------------------------------------------
// two_level_page_table_engine
// 32-bit two-level page table with map, unmap and translate requests.
// ---------------------------------------------------------------------------
//
//   channel   direction   ports
//   --------  ---------   ---------------------------------------------------
//   request   in          req_valid/req_ready, req_kind, req_virt_addr,
//                         req_phys_addr, req_page_flags
//   response  out         rsp_valid/rsp_ready, rsp_phys_result, rsp_mapped,
//                         rsp_status
//
// one word in flight: unmap, kind 3, map to an existing table and any
// request that fails at the directory is answered from the directory
// entry; translate of a present table also reads the table entry
// the first map under a directory entry allocates a table; the new table
// is swept clear one entry per cycle, mapping written on the way
// after reset the directory is swept clear, req_ready low
// a held response does not block acceptance of the next request; work
// stalls only at the point where it would overwrite the held response
// ---------------------------------------------------------------------------
module two_level_page_table_engine (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_kind,
   input  logic [tlpt_pkg::ADDR_W-1:0]   req_virt_addr,
   input  logic [tlpt_pkg::ADDR_W-1:0]   req_phys_addr,
   input  logic [tlpt_pkg::FLAGS_W-1:0]  req_page_flags,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [tlpt_pkg::ADDR_W-1:0]   rsp_phys_result,
   output logic                          rsp_mapped,
   output logic [1:0]                    rsp_status
);
   import tlpt_pkg::*;

   // command and status bundles between controller and datapath
   cmd_type cmd;
   sts_type sts;

   // sequencing, handshakes
   tlpt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // memories, free table counter, result registers
   tlpt_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_kind        (req_kind),
      .req_virt_addr   (req_virt_addr),
      .req_phys_addr   (req_phys_addr),
      .req_page_flags  (req_page_flags),
      .rsp_phys_result (rsp_phys_result),
      .rsp_mapped      (rsp_mapped),
      .rsp_status      (rsp_status)
   );

endmodule

>>> hdl/tlpt_checker.sv
// ---------------------------------------------------------------------------
// tlpt_checker
// Port-level checks for the page table engine, bound to the top level.
// ---------------------------------------------------------------------------
module tlpt_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [tlpt_pkg::ADDR_W-1:0]   rsp_phys_result,
   input logic                          rsp_mapped,
   input logic [1:0]                    rsp_status
);
   import tlpt_pkg::*;

   // held response keeps its word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_phys_result)
         && $stable(rsp_mapped) && $stable(rsp_status))
      else $error("response changed while stalled");

   // a translation hit always reports done
   a_mapped_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_mapped |-> rsp_status == ST_DONE)
      else $error("mapped with error status");

   // any failure carries a zero address and no hit
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_DONE |-> rsp_phys_result == '0 && !rsp_mapped)
      else $error("failed response with payload");

   // directory sweep follows reset
   a_reset_busy: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request taken during directory clear");

   // one request at a time
   a_one_word: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("back to back acceptance");

endmodule

bind two_level_page_table_engine tlpt_checker u_tlpt_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_phys_result (rsp_phys_result),
   .rsp_mapped      (rsp_mapped),
   .rsp_status      (rsp_status)
);
